// File: hdl/lph_pkg.sv
`default_nettype none

package lph_pkg;

    // Field widths that do not follow from the module parameters.
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 8;
    localparam int MARK_W     = 2;
    localparam int CFG_W      = 9;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Key bits retired per divider step.
    localparam int DIV_RADIX  = 4;

    // Register index of the slot count.
    localparam int REG_SLOTS_IN_USE = 0;

    // Operation codes.
    localparam logic [CMD_W-1:0] OP_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] OP_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Slot marks.
    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic div_step;
        logic mem_rd;
        logic probe_chk;
        logic res_push;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic chk_finish;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/lph_ctrl.sv
`default_nettype none

module lph_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_tvalid,
    output logic                   in_tready,
    input  wire lph_pkg::dp_stat_t stat,
    output lph_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.probe_chk = 1'b1;
                state_next    = stat.chk_finish ? S_DONE : S_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.res_push = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/lph_dp.sv
`default_nettype none

module lph_dp
#(
    parameter int SLOTS      = 256,
    parameter int KEY_BITS   = 31,
    parameter int VALUE_BITS = 32
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lph_pkg::ctrl_cmd_t          cmd,
    output lph_pkg::dp_stat_t                stat,
    input  wire logic [lph_pkg::CFG_W-1:0]   slots_cfg,
    input  wire logic
        [((lph_pkg::CMD_W + KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0]          in_tdata,
    output logic                             out_tvalid,
    input  wire logic                        out_tready,
    output logic
        [((lph_pkg::STATUS_W + lph_pkg::SLOT_W + VALUE_BITS + 7) / 8) * 8 - 1:0] out_tdata
);

    localparam int CMD_W     = lph_pkg::CMD_W;
    localparam int CFG_W     = lph_pkg::CFG_W;
    localparam int MARK_W    = lph_pkg::MARK_W;
    localparam int STATUS_W  = lph_pkg::STATUS_W;
    localparam int SLOT_W    = lph_pkg::SLOT_W;
    localparam int OUT_W     = ((STATUS_W + SLOT_W + VALUE_BITS + 7) / 8) * 8;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WIDE      = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;
    localparam int R         = lph_pkg::DIV_RADIX;
    localparam int DIV_STEPS = (KEY_BITS + R - 1) / R;
    localparam int DIV_BITS  = DIV_STEPS * R;
    localparam int DCNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int CFG_MAX   = (1 << CFG_W) - 1;
    localparam int NMAX      = (SLOTS > CFG_MAX) ? CFG_MAX : SLOTS;
    localparam int MEM_W     = MARK_W + KEY_BITS + VALUE_BITS;

    logic [MEM_W-1:0]      mem [SLOTS];
    logic [MEM_W-1:0]      mem_q_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [MEM_W-1:0]      mem_wdata;

    logic [CFG_W-1:0]      n_act;
    logic [WIDE-1:0]       n_w;

    logic [CMD_W-1:0]      in_cmd;
    logic [KEY_BITS-1:0]   in_key;
    logic [VALUE_BITS-1:0] in_val;

    logic [CMD_W-1:0]      op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [DIV_BITS-1:0]   div_sr_reg;
    logic [CFG_W-1:0]      rem_reg;
    logic [CFG_W-1:0]      rem_next;
    logic [DCNT_W-1:0]     dcnt_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [WIDE-1:0]       idx_w;
    logic [WIDE-1:0]       idx_inc;
    logic [CFG_W-1:0]      pcnt_reg;
    logic [CFG_W:0]        pcnt_inc;
    logic                  last_probe;
    logic [IDX_W-1:0]      clr_reg;

    logic [MARK_W-1:0]     m_mark;
    logic [KEY_BITS-1:0]   m_key;
    logic [VALUE_BITS-1:0] m_val;
    logic                  chk_finish;
    logic                  chk_we;
    logic                  chk_ok;
    logic [STATUS_W-1:0]   fail_status;
    logic [MEM_W-1:0]      chk_wdata;

    logic [STATUS_W-1:0]   st_status_reg;
    logic [SLOT_W-1:0]     st_slot_reg;
    logic [VALUE_BITS-1:0] st_value_reg;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [VALUE_BITS-1:0] out_value_reg;

    // A slot count of zero acts as one, and a count above the table as the table.
    always_comb
    begin
        if (slots_cfg == '0)
        begin
            n_act = CFG_W'(1);
        end
        else if (slots_cfg > CFG_W'(NMAX))
        begin
            n_act = CFG_W'(NMAX);
        end
        else
        begin
            n_act = slots_cfg;
        end
    end

    assign n_w    = WIDE'(n_act);
    assign in_cmd = in_tdata[CMD_W-1:0];
    assign in_key = in_tdata[CMD_W +: KEY_BITS];
    assign in_val = in_tdata[CMD_W + KEY_BITS +: VALUE_BITS];

    // Restoring remainder, R key bits per step, most significant first.
    always_comb
    begin
        logic [CFG_W:0] t;
        rem_next = rem_reg;
        for (int b = 0; b < R; b++)
        begin
            t = {rem_next, div_sr_reg[DIV_BITS-1-b]};
            if (t >= {1'b0, n_act})
            begin
                t = t - {1'b0, n_act};
            end
            rem_next = t[CFG_W-1:0];
        end
    end

    // Probe position: advance by one slot and wrap at the slot count.
    assign idx_w      = WIDE'(idx_reg);
    assign idx_inc    = idx_w + WIDE'(1);
    assign idx_next   = (idx_inc == n_w) ? '0 : idx_inc[IDX_W-1:0];
    assign pcnt_inc   = {1'b0, pcnt_reg} + (CFG_W + 1)'(1);
    assign last_probe = (pcnt_inc == {1'b0, n_act});

    assign m_mark = mem_q_reg[MEM_W-1 -: MARK_W];
    assign m_key  = mem_q_reg[VALUE_BITS +: KEY_BITS];
    assign m_val  = mem_q_reg[VALUE_BITS-1:0];

    always_comb
    begin
        logic is_free;
        logic is_empty;
        logic is_match;
        is_free     = (m_mark != lph_pkg::MARK_USED);
        is_empty    = (m_mark == lph_pkg::MARK_EMPTY);
        is_match    = (m_mark == lph_pkg::MARK_USED) && (m_key == key_reg);
        chk_finish  = 1'b1;
        chk_we      = 1'b0;
        chk_ok      = 1'b0;
        fail_status = lph_pkg::ST_NOT_FOUND;
        chk_wdata   = {lph_pkg::MARK_USED, key_reg, val_reg};
        unique case (op_reg)
            lph_pkg::OP_INSERT:
            begin
                chk_finish  = is_free || last_probe;
                chk_we      = is_free;
                chk_ok      = is_free;
                fail_status = lph_pkg::ST_FULL;
            end
            lph_pkg::OP_LOOKUP:
            begin
                chk_finish = is_empty || is_match || last_probe;
                chk_ok     = is_match;
            end
            lph_pkg::OP_REMOVE:
            begin
                chk_finish = is_empty || is_match || last_probe;
                chk_ok     = is_match;
                chk_we     = is_match;
                chk_wdata  = {lph_pkg::MARK_DELETED, m_key, m_val};
            end
            default:
            begin
                chk_finish = 1'b1;
            end
        endcase
    end

    assign mem_we    = cmd.clr_wr || (cmd.probe_chk && chk_we);
    assign mem_waddr = cmd.clr_wr ? clr_reg : idx_reg;
    assign mem_wdata = cmd.clr_wr ? {lph_pkg::MARK_EMPTY, {(MEM_W-MARK_W){1'b0}}} : chk_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            mem_q_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            dcnt_reg      <= '0;
            pcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cmd.load)
            begin
                dcnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            if (cmd.div_step && stat.div_last)
            begin
                pcnt_reg <= '0;
            end
            else if (cmd.probe_chk && !chk_finish)
            begin
                pcnt_reg <= pcnt_inc[CFG_W-1:0];
            end
            if (cmd.res_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_cmd;
            key_reg    <= in_key;
            val_reg    <= in_val;
            div_sr_reg <= DIV_BITS'(in_key);
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            div_sr_reg <= div_sr_reg << R;
            rem_reg    <= rem_next;
        end
        if (cmd.div_step && stat.div_last)
        begin
            idx_reg <= IDX_W'(WIDE'(rem_next));
        end
        else if (cmd.probe_chk && !chk_finish)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.probe_chk && chk_finish)
        begin
            st_status_reg <= chk_ok ? lph_pkg::ST_OK : fail_status;
            st_slot_reg   <= chk_ok ? idx_w[SLOT_W-1:0] : '0;
            st_value_reg  <= (chk_ok && (op_reg == lph_pkg::OP_LOOKUP)) ? m_val : '0;
        end
        if (cmd.res_push)
        begin
            out_status_reg <= st_status_reg;
            out_slot_reg   <= st_slot_reg;
            out_value_reg  <= st_value_reg;
        end
    end

    assign stat.clr_last   = (clr_reg == IDX_W'(SLOTS - 1));
    assign stat.div_last   = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
    assign stat.chk_finish = chk_finish;
    assign stat.out_free   = !out_valid_reg || out_tready;

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = OUT_W'({out_value_reg, out_slot_reg, out_status_reg});

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_push |-> (!out_valid_reg || out_tready))
        else $error("result pushed over an untaken result");

    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_push |=> out_valid_reg)
        else $error("pushed result not presented");

    a_rd_wr_apart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_rd |-> !mem_we)
        else $error("slot read and write in the same cycle");

    a_write_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.probe_chk && chk_we) |-> chk_finish)
        else $error("slot written without ending the probe");

endmodule

`default_nettype wire

// File: hdl/linear_probe_hash_table.sv
`default_nettype none

// Open-addressing hash table with linear probing and tombstones. Each
// stream item carries an operation (insert, lookup, remove), a key and a
// value, and yields exactly one result with a status, the slot used or
// found and, for a successful lookup, the stored value. A controller
// steers a datapath that first reduces the key modulo the configured slot
// count in a restoring remainder unit that retires four key bits per cycle,
// then probes the slot memory one slot at a time through its registered
// read port, reading a slot and then checking it. Items are worked one at
// a time, and the next item is accepted in the cycle after the result has
// moved to the output register. A stalled output holds the result in the
// datapath and delays the next acceptance. After reset the block runs a
// clearing pass that marks every slot empty; no item is accepted during
// it, while the configuration port works as usual.
module linear_probe_hash_table
#(
    parameter int SLOTS      = 256,
    parameter int KEY_BITS   = 31,
    parameter int VALUE_BITS = 32
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lph_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [lph_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [lph_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                     pready,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // Fields from bit 0 up: cmd, key, new_value, zero fill.
    input  wire logic
        [((lph_pkg::CMD_W + KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0]          s_tdata,

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // Fields from bit 0 up: status, slot, found_value, zero fill.
    output logic
        [((lph_pkg::STATUS_W + lph_pkg::SLOT_W + VALUE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CFG_W     = lph_pkg::CFG_W;
    localparam int CFG_MAX   = (1 << CFG_W) - 1;
    localparam int CFG_RESET = (SLOTS > CFG_MAX) ? CFG_MAX : SLOTS;

    logic [CFG_W-1:0]   slots_cfg_reg;
    logic               cfg_wr;
    logic               cfg_sel;
    lph_pkg::ctrl_cmd_t cmd;
    lph_pkg::dp_stat_t  stat;

    // The slot count register sits at byte address zero; the low two address
    // bits select bytes within the word and are ignored.
    assign cfg_sel = (paddr[2] == 1'(lph_pkg::REG_SLOTS_IN_USE));
    assign cfg_wr  = psel && penable && pwrite && cfg_sel;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? lph_pkg::APB_DATA_W'(slots_cfg_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_cfg_reg <= CFG_W'(CFG_RESET);
        end
        else if (cfg_wr)
        begin
            slots_cfg_reg <= pwdata[CFG_W-1:0];
        end
    end

    // The controller sequences clearing, division, probing and the hand-off
    // of the result to the output register.
    lph_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_tvalid),
        .in_tready (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the slot memory, the remainder unit, the probe
    // position and the output register.
    lph_dp
    #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .slots_cfg  (slots_cfg_reg),
        .in_tdata   (s_tdata),
        .out_tvalid (m_tvalid),
        .out_tready (m_tready),
        .out_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// File: bench/linear_probe_hash_table_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the linear probing hash table.
//
// A directed table of items runs first. Its rows cover the edges of the fields,
// every operation, tombstones, wraparound, duplicate keys, a full table and
// slot counts out of range. Random phases follow, each with its own slot count.
// Every accepted item goes through a model of the table kept in this bench.
// Every result that leaves the block is compared with the oldest prediction.
module linear_probe_hash_table_test;

    localparam int SLOTS      = 256;
    localparam int KEY_BITS   = 31;
    localparam int VALUE_BITS = 32;

    localparam int CMD_W      = lph_pkg::CMD_W;
    localparam int STATUS_W   = lph_pkg::STATUS_W;
    localparam int SLOT_W     = lph_pkg::SLOT_W;
    localparam int MARK_W     = lph_pkg::MARK_W;
    localparam int CFG_W      = lph_pkg::CFG_W;
    localparam int APB_ADDR_W = lph_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = lph_pkg::APB_DATA_W;

    // Stream widths: fields packed from bit 0 and padded to whole bytes.
    localparam int IN_W  = 72;
    localparam int OUT_W = 48;

    // The package names three commands. The fourth code must change nothing.
    localparam logic [CMD_W-1:0] OP_UNKNOWN = 2'd3;

    localparam int RANDOM_ITEMS   = 425;
    // This limit is set well above the slowest item and the clearing pass.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 600;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_W-1:0]     slot;
        logic [VALUE_BITS-1:0] found_value;
    } result_t;

    typedef enum logic [1:0] {
        ROW_ITEM,   // the result comes from the table model
        ROW_TYPED,  // the result is written in the row
        ROW_CFG     // the slot count is written while the table is idle
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [CFG_W-1:0]    count;
        logic [CMD_W-1:0]    cmd;
        logic [KEY_BITS-1:0] key;
        logic [VALUE_BITS-1:0] value;
        result_t             want;
    } row_t;

    localparam int DIRECTED_ROWS = 30;

    // The directed part. The comments say what each group of rows covers.
    row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_CFG,   9'd256, lph_pkg::OP_INSERT, 31'd0,         32'd0,         '0},
        // The table is empty, so every search misses.
        '{ROW_TYPED, 9'd0,   lph_pkg::OP_LOOKUP, 31'd0,         32'd0,
          '{lph_pkg::ST_NOT_FOUND, 8'd0, 32'd0}},
        '{ROW_TYPED, 9'd0,   lph_pkg::OP_REMOVE, 31'd5,         32'd0,
          '{lph_pkg::ST_NOT_FOUND, 8'd0, 32'd0}},
        '{ROW_TYPED, 9'd0,   OP_UNKNOWN,         31'h7FFF_FFFF, 32'hFFFF_FFFF,
          '{lph_pkg::ST_NOT_FOUND, 8'd0, 32'd0}},
        // These rows use the smallest and the largest key and value.
        '{ROW_TYPED, 9'd0,   lph_pkg::OP_INSERT, 31'd0,         32'hFFFF_FFFF,
          '{lph_pkg::ST_OK, 8'd0, 32'd0}},
        '{ROW_TYPED, 9'd0,   lph_pkg::OP_INSERT, 31'h7FFF_FFFF, 32'd0,
          '{lph_pkg::ST_OK, 8'd255, 32'd0}},
        '{ROW_TYPED, 9'd0,   lph_pkg::OP_LOOKUP, 31'h7FFF_FFFF, 32'h1234_5678,
          '{lph_pkg::ST_OK, 8'd255, 32'd0}},
        // This key collides with key 0. The next insert puts a second copy of key 0 in.
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_INSERT, 31'd256,       32'h1234_5678, '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_INSERT, 31'd0,         32'hA5A5_A5A5, '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_LOOKUP, 31'd0,         32'd0,         '0},
        // Removing the first copy leaves a tombstone. Later searches go past it.
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_REMOVE, 31'd0,         32'd0,         '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_LOOKUP, 31'd0,         32'd0,         '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_LOOKUP, 31'd256,       32'd0,         '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_INSERT, 31'd512,       32'h5A5A_5A5A, '0},
        // The probe starts at the top slot and wraps to slot 0.
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_INSERT, 31'd255,       32'h0F0F_0F0F, '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_LOOKUP, 31'd511,       32'd0,         '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_REMOVE, 31'd255,       32'd0,         '0},
        // A table of one slot that is already used has no room left.
        '{ROW_CFG,   9'd1,   lph_pkg::OP_INSERT, 31'd0,         32'd0,         '0},
        '{ROW_TYPED, 9'd0,   lph_pkg::OP_INSERT, 31'd9,         32'd1,
          '{lph_pkg::ST_FULL, 8'd0, 32'd0}},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_LOOKUP, 31'd512,       32'd0,         '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_REMOVE, 31'd512,       32'd0,         '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_INSERT, 31'd9,         32'd1,         '0},
        // A slot count of zero has to act as one slot.
        '{ROW_CFG,   9'd0,   lph_pkg::OP_INSERT, 31'd0,         32'd0,         '0},
        '{ROW_TYPED, 9'd0,   lph_pkg::OP_INSERT, 31'd3,         32'd2,
          '{lph_pkg::ST_FULL, 8'd0, 32'd0}},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_LOOKUP, 31'd9,         32'd0,         '0},
        // A count above the slot total is clipped to it. The table keeps its contents.
        '{ROW_CFG,   9'd511, lph_pkg::OP_INSERT, 31'd0,         32'd0,         '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_LOOKUP, 31'd9,         32'd0,         '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_LOOKUP, 31'd256,       32'd0,         '0},
        '{ROW_CFG,   9'd3,   lph_pkg::OP_INSERT, 31'd0,         32'd0,         '0},
        '{ROW_ITEM,  9'd0,   lph_pkg::OP_LOOKUP, 31'd0,         32'd0,         '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    // Fields from bit 0 up: cmd, key, new_value, zero fill.
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // Fields from bit 0 up: status, slot, found_value, zero fill.
    logic [OUT_W-1:0]      m_tdata;

    // The table model: a copy of the slot marks, keys and values, and the slot count.
    logic [MARK_W-1:0]     marks       [SLOTS];
    logic [KEY_BITS-1:0]   keys_held   [SLOTS];
    logic [VALUE_BITS-1:0] values_held [SLOTS];
    logic [CFG_W-1:0]      slot_count;

    result_t               pending_results [$];
    logic [KEY_BITS-1:0]   key_pool [$];
    int                    mismatch_count;
    int                    burst_left;
    int                    idle_cycles;

    logic [CFG_W-1:0]      phase_count;
    logic [CMD_W-1:0]      rand_cmd;
    logic [KEY_BITS-1:0]   rand_key;
    int                    random_sent;
    int                    phase_len;
    int                    pick;
    int                    stall_mode;
    int                    mode_left;

    linear_probe_hash_table #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // A slot count out of range is clipped to 1..SLOTS before it is used.
    function automatic int active_slots();
        int n;
        n = slot_count;
        if (n == 0)
            n = 1;
        if (n > SLOTS)
            n = SLOTS;
        return n;
    endfunction

    // Searches in probe order. Deleted slots are skipped and an empty slot ends the search.
    // The result is the slot that holds the key, or -1 if there is none.
    function automatic int find_used(input logic [KEY_BITS-1:0] key, input int n);
        int idx;
        int hit;
        idx = key % n;
        hit = -1;
        for (int i = 0; i < n; i++)
        begin
            if (marks[idx] == lph_pkg::MARK_EMPTY)
                break;
            if (marks[idx] == lph_pkg::MARK_USED && keys_held[idx] == key)
            begin
                hit = idx;
                break;
            end
            idx = (idx + 1 == n) ? 0 : idx + 1;
        end
        return hit;
    endfunction

    // Applies one item to the table model and returns the result that it gives.
    function automatic result_t hash_table_op(input logic [CMD_W-1:0] cmd,
                                              input logic [KEY_BITS-1:0] key,
                                              input logic [VALUE_BITS-1:0] value);
        result_t r;
        int      n;
        int      idx;
        int      hit;
        n = active_slots();
        r = '{lph_pkg::ST_NOT_FOUND, '0, '0};
        case (cmd)
            lph_pkg::OP_INSERT:
            begin
                // Insert does not look for a copy of the key that is already there.
                // It takes the first slot that is not in use.
                r.status = lph_pkg::ST_FULL;
                idx = key % n;
                for (int i = 0; i < n; i++)
                begin
                    if (marks[idx] != lph_pkg::MARK_USED)
                    begin
                        marks[idx]       = lph_pkg::MARK_USED;
                        keys_held[idx]   = key;
                        values_held[idx] = value;
                        r.status         = lph_pkg::ST_OK;
                        r.slot           = SLOT_W'(idx);
                        break;
                    end
                    idx = (idx + 1 == n) ? 0 : idx + 1;
                end
            end
            lph_pkg::OP_LOOKUP:
            begin
                hit = find_used(key, n);
                if (hit >= 0)
                begin
                    r.status      = lph_pkg::ST_OK;
                    r.slot        = SLOT_W'(hit);
                    r.found_value = values_held[hit];
                end
            end
            lph_pkg::OP_REMOVE:
            begin
                hit = find_used(key, n);
                if (hit >= 0)
                begin
                    marks[hit] = lph_pkg::MARK_DELETED;
                    r.status   = lph_pkg::ST_OK;
                    r.slot     = SLOT_W'(hit);
                end
            end
            default:
            begin
                // An unknown command leaves the table alone and reports a miss.
            end
        endcase
        return r;
    endfunction

    // Prints one line for each mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Writes the slot count during a setup and an access cycle, then reads it back.
    task automatic write_slot_count(input logic [CFG_W-1:0] count);
        logic [APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(lph_pkg::REG_SLOTS_IN_USE * 4);
        pwdata  <= APB_DATA_W'(count);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        slot_count = count;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DATA_W'(count))
            report_mismatch("slot count readback", 64'(readback), 64'(count));
    endtask

    // Offers one item and holds it until it is accepted. The prediction is stored
    // at acceptance. When a burst ends, the sender waits a random gap.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_BITS-1:0] key,
                             input logic [VALUE_BITS-1:0] value, input bit use_typed,
                             input result_t typed);
        result_t predicted;
        int      gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, value, key, cmd};
        do
        begin
            @(posedge clk);
        end
        while (s_tready !== 1'b1);
        predicted = hash_table_op(cmd, key, value);
        pending_results.push_back(use_typed ? typed : predicted);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 12);
            // With no gap, valid stays high and the next item follows at once.
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stops the sender and waits until every pending result has arrived.
    // The table is idle after that, and its slot count may be changed.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Checks one result against the oldest pending prediction.
    task automatic check_result(input logic [OUT_W-1:0] beat);
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with no pending item", 64'(beat), 64'd0);
        end
        else
        begin
            want = pending_results.pop_front();
            if (beat[1:0] !== want.status)
                report_mismatch("status", 64'(beat[1:0]), 64'(want.status));
            if (beat[9:2] !== want.slot)
                report_mismatch("slot", 64'(beat[9:2]), 64'(want.slot));
            if (beat[41:10] !== want.found_value)
                report_mismatch("found_value", 64'(beat[41:10]), 64'(want.found_value));
        end
    endtask

    // Reset is asserted once at the start and then released.
    // Every input starts at a known value.
    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // The receiver stalls in a pattern of its own. It switches between always ready,
    // ready at random, and mostly stalled, and picks each mode and its length at random.
    initial
    begin
        m_tready  <= 1'b0;
        stall_mode = 0;
        mode_left  = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                check_result(m_tdata);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(1, 80);
            end
            mode_left--;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // The run ends with a mismatch report if no item moves on either side until the watchdog limit.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
                (m_tvalid === 1'b1 && m_tready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        burst_left     = 1;
        slot_count     = CFG_W'(SLOTS);
        for (int i = 0; i < SLOTS; i++)
            marks[i] = lph_pkg::MARK_EMPTY;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);

        // Directed part. The first write falls in the clearing pass after reset,
        // when the configuration port already works.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                wait_drained();
                write_slot_count(directed_rows[r].count);
            end
            else
            begin
                send_item(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].value,
                          directed_rows[r].kind == ROW_TYPED, directed_rows[r].want);
            end
        end

        // Random part. Each phase drains the table and sets a new slot count.
        // Most counts are small, so the table fills up and the probes wrap around.
        // Keys come from earlier inserts for most items, so lookups and removes
        // find their keys. The other keys are small or random over the whole range.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_drained();
            case ($urandom_range(0, 9))
                0, 1, 2: phase_count = CFG_W'($urandom_range(1, 4));
                3, 4, 5: phase_count = CFG_W'($urandom_range(5, 16));
                6:       phase_count = CFG_W'($urandom_range(17, 64));
                7:       phase_count = CFG_W'(SLOTS);
                8:       phase_count = CFG_W'($urandom_range(SLOTS + 1, 511));
                default: phase_count = '0;
            endcase
            write_slot_count(phase_count);
            phase_len = $urandom_range(20, 50);
            for (int j = 0; j < phase_len && random_sent < RANDOM_ITEMS; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    rand_cmd = lph_pkg::OP_INSERT;
                else if (pick < 75)
                    rand_cmd = lph_pkg::OP_LOOKUP;
                else if (pick < 95)
                    rand_cmd = lph_pkg::OP_REMOVE;
                else
                    rand_cmd = OP_UNKNOWN;
                pick = $urandom_range(0, 99);
                if (key_pool.size() != 0 && pick < 55)
                    rand_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                else if (pick < 80)
                    rand_key = KEY_BITS'($urandom_range(0, 600));
                else
                    rand_key = KEY_BITS'($urandom);
                if (rand_cmd == lph_pkg::OP_INSERT)
                begin
                    key_pool.push_back(rand_key);
                    if (key_pool.size() > 64)
                        void'(key_pool.pop_front());
                end
                send_item(rand_cmd, rand_key, VALUE_BITS'($urandom), 1'b0, '0);
                random_sent++;
                // Halfway through, the sender stops until every result has arrived.
                if (random_sent == RANDOM_ITEMS / 2)
                    wait_drained();
            end
        end

        // All items are in. Wait for the last results and then watch for extra ones.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
